### rtl/wrts_pkg.sv
// Shared types, constants and helpers for the weighted route table selector.
// Used by the lanes, the merge stage, the remainder unit, the top level and the checker.
// Depends on nothing else.
package wrts_pkg;

  // Default sizes of the tables.
  localparam int NUM_LINKS_DEF   = 8;
  localparam int NUM_VNETS_DEF   = 4;
  localparam int NUM_NODES_DEF   = 64;
  localparam int WEIGHT_BITS_DEF = 16;

  // Pick LFSR: Galois form, x^16+x^14+x^13+x^11+1.
  localparam int                LFSR_W    = 16;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h0001;

  // Remainder unit retires this many dividend bits per cycle.
  localparam int DIV_STEP_BITS = 4;

  // Free VC counts arrive as one nibble per link for the first links only.
  localparam int FREE_BITS  = 4;
  localparam int FREE_LANES = 8;

  // Configuration port.
  localparam int CFG_ADDR_W  = 3;
  localparam int REG_ORDERED = 0;

  typedef enum logic [1:0] {
    MODE_MASK_WR   = 2'd0,
    MODE_WEIGHT_WR = 2'd1,
    MODE_TABLE     = 2'd2,
    MODE_ADAPT     = 2'd3
  } mode_t;

  // Stage enables that the sequencer hands to the lanes and the merge stage.
  typedef struct packed {
    logic hit_en;
    logic min_en;
    logic cand_en;
    logic sum_en;
  } stage_ctl_t;

  // One step of the pick LFSR.
  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] cur);
    logic [LFSR_W-1:0] shifted;
    shifted = cur >> 1;
    return cur[0] ? (shifted ^ LFSR_TAPS) : shifted;
  endfunction

endpackage

### rtl/wrts_lane.sv
// One output-link lane: the link's route masks for every vnet, its weight,
// and the per-link hit and candidate flags. Depends on wrts_pkg.
module wrts_lane
  import wrts_pkg::*;
#(
  parameter int NUM_VNETS   = NUM_VNETS_DEF,
  parameter int NUM_NODES   = NUM_NODES_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
  parameter int LANE        = 0,
  localparam int VNET_AW    = (NUM_VNETS > 1) ? $clog2(NUM_VNETS) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  stage_ctl_t             ctl,
  input  logic                   mask_wr,
  input  logic                   weight_wr,
  input  logic [2:0]             wr_link,
  input  logic [VNET_AW-1:0]     wr_vnet,
  input  logic [NUM_NODES-1:0]   wr_mask,
  input  logic [WEIGHT_BITS-1:0] wr_weight,
  input  logic                   look_ok,
  input  logic [VNET_AW-1:0]     look_vnet,
  input  logic [NUM_NODES-1:0]   look_dest,
  input  logic [WEIGHT_BITS-1:0] floor_weight,
  output logic                   hit,
  output logic                   cand,
  output logic [WEIGHT_BITS-1:0] weight
);

  logic [NUM_NODES-1:0] masks [NUM_VNETS];
  logic                 sel;

  // This lane owns writes addressed to its link.
  assign sel = (int'(wr_link) == LANE);

  // Table storage and the two lookup flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int v = 0; v < NUM_VNETS; v++) begin
        masks[v] <= '0;
      end
      weight <= '0;
      hit    <= 1'b0;
      cand   <= 1'b0;
    end else begin
      if (mask_wr && sel) begin
        masks[wr_vnet] <= wr_mask;
      end
      if (weight_wr && sel) begin
        weight <= wr_weight;
      end
      if (ctl.hit_en) begin
        hit <= look_ok && (|(masks[look_vnet] & look_dest));
      end
      if (ctl.cand_en) begin
        cand <= hit && (weight == floor_weight);
      end
    end
  end

endmodule

### rtl/wrts_merge.sv
// Merge stage: minimum weight over hitting lanes, candidate count, the
// adaptive pick and the n-th candidate pick. Depends on wrts_pkg.
module wrts_merge
  import wrts_pkg::*;
#(
  parameter int NUM_LINKS   = NUM_LINKS_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
  localparam int LINK_AW    = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1,
  localparam int CNT_W      = $clog2(NUM_LINKS + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  stage_ctl_t             ctl,
  input  logic [NUM_LINKS-1:0]   hits,
  input  logic [WEIGHT_BITS-1:0] weights [NUM_LINKS],
  input  logic [NUM_LINKS-1:0]   cands,
  input  logic [31:0]            free_vcs,
  input  logic [CNT_W-1:0]       target,
  output logic [WEIGHT_BITS-1:0] floor_weight,
  output logic [CNT_W-1:0]       count,
  output logic [LINK_AW-1:0]     adapt_sel,
  output logic [LINK_AW-1:0]     pick_sel
);

  localparam int LEVELS = LINK_AW;
  localparam int P      = 1 << LINK_AW;

  logic [FREE_BITS-1:0]   lane_free [NUM_LINKS];
  logic [WEIGHT_BITS-1:0] mw [LEVELS+1][P];
  logic                   mv [LEVELS+1][P];
  logic [FREE_BITS-1:0]   fw [LEVELS+1][P];
  logic [LINK_AW-1:0]     fi [LEVELS+1][P];
  logic                   fv [LEVELS+1][P];
  logic [CNT_W-1:0]       count_c;

  // Free VC nibble of each link; links past the nibble field have none.
  for (genvar g = 0; g < NUM_LINKS; g++) begin : g_free
    if (g < FREE_LANES) begin : g_on
      assign lane_free[g] = free_vcs[FREE_BITS*g +: FREE_BITS];
    end else begin : g_off
      assign lane_free[g] = '0;
    end
  end

  // Minimum weight tree over the hitting lanes.
  always_comb begin
    for (int l = 0; l <= LEVELS; l++) begin
      for (int j = 0; j < P; j++) begin
        mw[l][j] = '0;
        mv[l][j] = 1'b0;
      end
    end
    for (int j = 0; j < NUM_LINKS; j++) begin
      mw[0][j] = weights[j];
      mv[0][j] = hits[j];
    end
    for (int l = 0; l < LEVELS; l++) begin
      for (int j = 0; j < (P >> (l + 1)); j++) begin
        if (mv[l][2*j] && (!mv[l][2*j+1] || mw[l][2*j] <= mw[l][2*j+1])) begin
          mw[l+1][j] = mw[l][2*j];
          mv[l+1][j] = mv[l][2*j];
        end else begin
          mw[l+1][j] = mw[l][2*j+1];
          mv[l+1][j] = mv[l][2*j+1];
        end
      end
    end
  end

  // Most free VCs among the candidates; the lower link wins a tie.
  always_comb begin
    for (int l = 0; l <= LEVELS; l++) begin
      for (int j = 0; j < P; j++) begin
        fw[l][j] = '0;
        fi[l][j] = '0;
        fv[l][j] = 1'b0;
      end
    end
    for (int j = 0; j < NUM_LINKS; j++) begin
      fw[0][j] = lane_free[j];
      fi[0][j] = LINK_AW'(j);
      fv[0][j] = cands[j];
    end
    for (int l = 0; l < LEVELS; l++) begin
      for (int j = 0; j < (P >> (l + 1)); j++) begin
        if (fv[l][2*j] && (!fv[l][2*j+1] || fw[l][2*j] >= fw[l][2*j+1])) begin
          fw[l+1][j] = fw[l][2*j];
          fi[l+1][j] = fi[l][2*j];
          fv[l+1][j] = fv[l][2*j];
        end else begin
          fw[l+1][j] = fw[l][2*j+1];
          fi[l+1][j] = fi[l][2*j+1];
          fv[l+1][j] = fv[l][2*j+1];
        end
      end
    end
  end

  // Number of candidates.
  always_comb begin
    count_c = '0;
    for (int i = 0; i < NUM_LINKS; i++) begin
      count_c = count_c + CNT_W'(cands[i]);
    end
  end

  // Candidate number target in ascending link order.
  always_comb begin : pick_blk
    logic [CNT_W-1:0] seen;
    logic             found;
    seen     = '0;
    found    = 1'b0;
    pick_sel = '0;
    for (int i = 0; i < NUM_LINKS; i++) begin
      if (cands[i] && !found) begin
        if (seen == target) begin
          pick_sel = LINK_AW'(i);
          found    = 1'b1;
        end
        seen = seen + CNT_W'(1);
      end
    end
  end

  // Registered merge results.
  always_ff @(posedge clk) begin
    if (rst) begin
      floor_weight <= '0;
      count        <= '0;
      adapt_sel    <= '0;
    end else begin
      if (ctl.min_en) begin
        floor_weight <= mw[LEVELS][0];
      end
      if (ctl.sum_en) begin
        count     <= count_c;
        adapt_sel <= fi[LEVELS][0];
      end
    end
  end

endmodule

### rtl/wrts_mod.sv
// Iterative remainder unit: pick LFSR value modulo the candidate count,
// a few dividend bits per cycle. Depends on wrts_pkg.
module wrts_mod
  import wrts_pkg::*;
#(
  parameter int DIVISOR_W = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [LFSR_W-1:0]    dividend,
  input  logic [DIVISOR_W-1:0] divisor,
  output logic                 done,
  output logic [DIVISOR_W-1:0] rem
);

  localparam int STEPS   = LFSR_W / DIV_STEP_BITS;
  localparam int STEP_CW = $clog2(STEPS + 1);

  logic [LFSR_W-1:0]    num;
  logic [DIVISOR_W-1:0] div_q;
  logic [STEP_CW-1:0]   left;
  logic [DIVISOR_W-1:0] rem_next;

  // Restoring remainder over the next few dividend bits.
  always_comb begin : step_blk
    logic [DIVISOR_W:0] r;
    r = {1'b0, rem};
    for (int b = 0; b < DIV_STEP_BITS; b++) begin
      r = {r[DIVISOR_W-1:0], num[LFSR_W-1-b]};
      if (r >= {1'b0, div_q}) begin
        r = r - {1'b0, div_q};
      end
    end
    rem_next = r[DIVISOR_W-1:0];
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        left <= STEP_CW'(STEPS);
      end else if (left != '0) begin
        left <= left - STEP_CW'(1);
        if (left == STEP_CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // Dividend, divisor and partial remainder.
  always_ff @(posedge clk) begin
    if (start) begin
      num   <= dividend;
      div_q <= divisor;
      rem   <= '0;
    end else if (left != '0) begin
      num <= num << DIV_STEP_BITS;
      rem <= rem_next;
    end
  end

endmodule

### rtl/weighted_route_table_select_core.sv
// Lookups: an adaptive lookup, an ordered-vnet lookup or a lookup with no route gives its
// word from the decide state, after the look, min, cand and sum states; busy holds off new words.
// A table lookup on an unordered vnet goes on through the four-step remainder unit that
// reduces the pick LFSR modulo the candidate count, and gives its word when that unit is done.
// Write words do not make the block busy. The receiver cannot stall; done pulses for one cycle.
// Reset clears masks, weights and ordered_vnets, sets the pick LFSR to one; no clearing pass.
module weighted_route_table_select_core
  import wrts_pkg::*;
#(
  parameter int NUM_LINKS   = NUM_LINKS_DEF,
  parameter int NUM_VNETS   = NUM_VNETS_DEF,
  parameter int NUM_NODES   = NUM_NODES_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            mode,
  input  logic [1:0]            vnet,
  input  logic [2:0]            link,
  input  logic [63:0]           dest_mask,
  input  logic [15:0]           weight,
  input  logic [31:0]           free_vcs,
  output logic                  done,
  output logic [2:0]            out_link,
  output logic                  no_route,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int VNET_AW = (NUM_VNETS > 1) ? $clog2(NUM_VNETS) : 1;
  localparam int LINK_AW = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;
  localparam int CNT_W   = $clog2(NUM_LINKS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_MIN,
    S_CAND,
    S_SUM,
    S_DECIDE,
    S_DIV
  } state_t;

  state_t                 state;
  stage_ctl_t             ctl;
  logic                   accept;
  logic                   lookup_acc;
  logic                   in_vnet_ok;
  logic                   mask_wr;
  logic                   weight_wr;
  logic [VNET_AW-1:0]     in_vnet;
  logic [NUM_NODES-1:0]   in_dest;
  logic [WEIGHT_BITS-1:0] in_weight;
  logic [3:0]             ordered_vnets;
  logic [LFSR_W-1:0]      lfsr;
  logic                   cfg_wr;
  logic                   cfg_hit;

  // Request captured for the lookup in flight.
  logic [VNET_AW-1:0]     req_vnet;
  logic                   req_ok;
  logic [NUM_NODES-1:0]   req_dest;
  logic [31:0]            req_free;
  logic                   req_adapt;
  logic                   req_ordered;
  logic [LFSR_W-1:0]      lfsr_snap;

  // Lane and merge signals.
  logic [NUM_LINKS-1:0]   lane_hit;
  logic [NUM_LINKS-1:0]   lane_cand;
  logic [WEIGHT_BITS-1:0] lane_weight [NUM_LINKS];
  logic [WEIGHT_BITS-1:0] floor_weight;
  logic [CNT_W-1:0]       count;
  logic [LINK_AW-1:0]     adapt_sel;
  logic [LINK_AW-1:0]     pick_sel;
  logic [CNT_W-1:0]       target;
  logic                   div_start;
  logic                   div_done;
  logic [CNT_W-1:0]       div_rem;

  // Input handshake and write decode.
  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign lookup_acc = accept && (mode inside {MODE_TABLE, MODE_ADAPT});
  assign in_vnet_ok = (int'(vnet) < NUM_VNETS);
  assign mask_wr    = accept && (mode == MODE_MASK_WR) && in_vnet_ok;
  assign weight_wr  = accept && (mode == MODE_WEIGHT_WR);
  assign in_vnet    = VNET_AW'(vnet);
  assign in_dest    = dest_mask[NUM_NODES-1:0];
  assign in_weight  = WEIGHT_BITS'(weight);

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[CFG_ADDR_W-1:2] == (CFG_ADDR_W-2)'(REG_ORDERED));
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
  assign prdata  = cfg_hit ? {28'd0, ordered_vnets} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ordered_vnets <= '0;
    end else if (cfg_wr) begin
      ordered_vnets <= pwdata[3:0];
    end
  end

  // Pick LFSR steps once per accepted table lookup.
  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= LFSR_SEED;
    end else if (accept && (mode == MODE_TABLE)) begin
      lfsr <= lfsr_next(lfsr);
    end
  end

  // Capture the lookup request.
  always_ff @(posedge clk) begin
    if (lookup_acc) begin
      req_vnet    <= in_vnet;
      req_ok      <= in_vnet_ok;
      req_dest    <= in_dest;
      req_free    <= free_vcs;
      req_adapt   <= (mode == MODE_ADAPT);
      req_ordered <= ordered_vnets[vnet];
      lfsr_snap   <= lfsr;
    end
  end

  // Stage enables for the lanes and the merge stage.
  always_comb begin
    ctl         = '0;
    ctl.hit_en  = (state == S_LOOK);
    ctl.min_en  = (state == S_MIN);
    ctl.cand_en = (state == S_CAND);
    ctl.sum_en  = (state == S_SUM);
  end

  assign div_start = (state == S_DECIDE) && (count != '0) && !req_adapt && !req_ordered;
  assign target    = (state == S_DIV) ? div_rem : '0;

  // One lane per output link.
  for (genvar g = 0; g < NUM_LINKS; g++) begin : g_lane
    wrts_lane #(
      .NUM_VNETS  (NUM_VNETS),
      .NUM_NODES  (NUM_NODES),
      .WEIGHT_BITS(WEIGHT_BITS),
      .LANE       (g)
    ) u_lane (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .mask_wr     (mask_wr),
      .weight_wr   (weight_wr),
      .wr_link     (link),
      .wr_vnet     (in_vnet),
      .wr_mask     (in_dest),
      .wr_weight   (in_weight),
      .look_ok     (req_ok),
      .look_vnet   (req_vnet),
      .look_dest   (req_dest),
      .floor_weight(floor_weight),
      .hit         (lane_hit[g]),
      .cand        (lane_cand[g]),
      .weight      (lane_weight[g])
    );
  end

  wrts_merge #(
    .NUM_LINKS  (NUM_LINKS),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_merge (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .hits        (lane_hit),
    .weights     (lane_weight),
    .cands       (lane_cand),
    .free_vcs    (req_free),
    .target      (target),
    .floor_weight(floor_weight),
    .count       (count),
    .adapt_sel   (adapt_sel),
    .pick_sel    (pick_sel)
  );

  wrts_mod #(
    .DIVISOR_W(CNT_W)
  ) u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(lfsr_snap),
    .divisor (count),
    .done    (div_done),
    .rem     (div_rem)
  );

  // Lookup sequencer and result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      out_link <= '0;
      no_route <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (lookup_acc) begin
            state <= S_LOOK;
          end
        end
        S_LOOK:   state <= S_MIN;
        S_MIN:    state <= S_CAND;
        S_CAND:   state <= S_SUM;
        S_SUM:    state <= S_DECIDE;
        S_DECIDE: begin
          if (count == '0) begin
            done     <= 1'b1;
            out_link <= '0;
            no_route <= 1'b1;
            state    <= S_IDLE;
          end else if (req_adapt) begin
            done     <= 1'b1;
            out_link <= 3'(adapt_sel);
            no_route <= 1'b0;
            state    <= S_IDLE;
          end else if (req_ordered) begin
            done     <= 1'b1;
            out_link <= 3'(pick_sel);
            no_route <= 1'b0;
            state    <= S_IDLE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            done     <= 1'b1;
            out_link <= 3'(pick_sel);
            no_route <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/wrts_checker.sv
// Port-level checker for the weighted route table selector, bound to the top level.
// Depends on wrts_pkg and weighted_route_table_select_core.
module wrts_checker
  import wrts_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] mode,
  input logic       done,
  input logic [2:0] out_link,
  input logic       no_route
);

  // A word without a route always carries link zero.
  a_no_route_link: assert property (@(posedge clk) disable iff (rst)
    done && no_route |-> out_link == 3'd0)
    else $error("no_route word with nonzero out_link");

  // A taken lookup keeps the block busy in the next cycle.
  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (mode == MODE_TABLE || mode == MODE_ADAPT) |=> busy)
    else $error("lookup taken but block not busy");

  // A taken write leaves the block free in the next cycle.
  a_write_free: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (mode == MODE_MASK_WR || mode == MODE_WEIGHT_WR) |=> !busy)
    else $error("write word stalled the block");

  // Result words never come in adjacent cycles.
  a_done_spaced: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result words in adjacent cycles");

  // The block is free while its result word is shown.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy while showing a result word");

endmodule

bind weighted_route_table_select_core wrts_checker u_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .mode    (mode),
  .done    (done),
  .out_link(out_link),
  .no_route(no_route)
);

### test/weighted_route_table_select_core_test.sv
// Self-checking testbench for weighted_route_table_select_core: random and directed words
// go through the start/busy port and are checked against an in-bench route predictor.
// Depends on wrts_pkg and the core RTL.
`timescale 1ns / 1ps

module weighted_route_table_select_core_test;
  import wrts_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 15;
  localparam int PHASE_WORDS   = 330;

  localparam logic [CFG_ADDR_W-1:0] ORDERED_ADDR = CFG_ADDR_W'(REG_ORDERED * 4);
  localparam logic [CFG_ADDR_W-1:0] UNUSED_ADDR  = CFG_ADDR_W'(4);

  typedef struct {
    mode_t       mode;
    logic [1:0]  vnet;
    logic [2:0]  link;
    logic [63:0] dest;
    logic [15:0] weight;
    logic [31:0] free_vcs;
  } route_word_t;

  typedef struct {
    logic [2:0] out_link;
    logic       no_route;
  } route_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            mode = '0;
  logic [1:0]            vnet = '0;
  logic [2:0]            link = '0;
  logic [63:0]           dest_mask = '0;
  logic [15:0]           weight = '0;
  logic [31:0]           free_vcs = '0;
  logic                  done;
  logic [2:0]            out_link;
  logic                  no_route;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  // Predictor copy of the tables and the pick LFSR.
  logic [63:0] mask_table [4][8];
  logic [15:0] weight_table [8];
  logic [15:0] pick_state;
  logic [3:0]  ordered_bits;

  route_word_t   pending_words[$];
  route_result_t expected_routes[$];
  route_word_t   live_word;
  route_result_t want_route;
  route_result_t got_route;
  int            words_queued = 0;
  int            words_taken = 0;
  int            idle_pct = 25;
  int            errors = 0;
  int            cycle_count = 0;

  weighted_route_table_select_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .mode      (mode),
    .vnet      (vnet),
    .link      (link),
    .dest_mask (dest_mask),
    .weight    (weight),
    .free_vcs  (free_vcs),
    .done      (done),
    .out_link  (out_link),
    .no_route  (no_route),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one accepted word to the predictor; returns 1 when it yields a route result.
  function automatic bit select_route(input route_word_t w, output route_result_t r);
    logic [7:0]  cand;
    logic [15:0] min_w;
    bit          any;
    bit          found;
    int          count;
    int          target;
    int          seen;
    int          best;
    int          sel;
    cand   = '0;
    min_w  = '0;
    any    = 1'b0;
    found  = 1'b0;
    count  = 0;
    target = 0;
    seen   = 0;
    best   = -1;
    sel    = 0;
    r      = '{out_link: '0, no_route: 1'b1};
    if (w.mode == MODE_MASK_WR) begin
      mask_table[w.vnet][w.link] = w.dest;
      return 1'b0;
    end
    if (w.mode == MODE_WEIGHT_WR) begin
      weight_table[w.link] = w.weight;
      return 1'b0;
    end
    // Minimum weight over every link that reaches any destination node.
    for (int i = 0; i < 8; i++) begin
      if ((mask_table[w.vnet][i] & w.dest) != '0) begin
        if (!any || weight_table[i] < min_w) min_w = weight_table[i];
        any = 1'b1;
      end
    end
    for (int i = 0; i < 8; i++) begin
      cand[i] = any && ((mask_table[w.vnet][i] & w.dest) != '0) && weight_table[i] == min_w;
      if (cand[i]) count++;
    end
    if (count != 0) begin
      if (w.mode == MODE_TABLE) begin
        if (!ordered_bits[w.vnet]) target = int'(pick_state) % count;
        for (int i = 0; i < 8; i++) begin
          if (cand[i]) begin
            if (!found && seen == target) begin
              sel   = i;
              found = 1'b1;
            end
            seen++;
          end
        end
      end else begin
        // Most free VCs wins; a strict compare keeps the lowest link on a tie.
        for (int i = 0; i < 8; i++) begin
          if (cand[i] && int'(w.free_vcs[4*i +: 4]) > best) begin
            best = int'(w.free_vcs[4*i +: 4]);
            sel  = i;
          end
        end
      end
      r.out_link = sel[2:0];
      r.no_route = 1'b0;
    end
    // The pick LFSR steps after every table lookup, route or not.
    if (w.mode == MODE_TABLE)
      pick_state = pick_state[0] ? ((pick_state >> 1) ^ LFSR_TAPS) : (pick_state >> 1);
    return 1'b1;
  endfunction

  function automatic route_word_t make_word(input mode_t m, input logic [1:0] v,
                                            input logic [2:0] l, input logic [63:0] d,
                                            input logic [15:0] wt, input logic [31:0] f);
    route_word_t w;
    w.mode     = m;
    w.vnet     = v;
    w.link     = l;
    w.dest     = d;
    w.weight   = wt;
    w.free_vcs = f;
    return w;
  endfunction

  function automatic void queue_word(input route_word_t w);
    pending_words.insert(pending_words.size(), w);
    words_queued++;
  endfunction

  // Node sets from empty through sparse to full, so lookups hit partial link subsets.
  function automatic logic [63:0] random_nodes();
    logic [63:0] m;
    case ($urandom_range(0, 5))
      0: m = '0;
      1: m = 64'h1 << $urandom_range(0, 63);
      2: m = {$urandom, $urandom};
      3: m = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      4: m = '1;
      default: m = (64'h1 << $urandom_range(0, 63)) | (64'h1 << $urandom_range(0, 63));
    endcase
    return m;
  endfunction

  function automatic route_word_t random_word();
    route_word_t w;
    int          pick;
    logic [3:0]  nib;
    pick = $urandom_range(0, 99);
    if (pick < 25)      w.mode = MODE_MASK_WR;
    else if (pick < 38) w.mode = MODE_WEIGHT_WR;
    else if (pick < 69) w.mode = MODE_TABLE;
    else                w.mode = MODE_ADAPT;
    w.vnet = 2'($urandom_range(0, 3));
    w.link = 3'($urandom_range(0, 7));
    w.dest = random_nodes();
    // Small weights give frequent ties at the minimum.
    w.weight = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    nib = 4'($urandom_range(0, 15));
    w.free_vcs = ($urandom_range(0, 3) == 0) ? {8{nib}} : $urandom;
    return w;
  endfunction

  // Waits until every queued word was taken and every expected result came back.
  task automatic wait_drained();
    do @(posedge clk); while (words_taken != words_queued || expected_routes.size() != 0);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if ((addr >> 2) == REG_ORDERED) ordered_bits = data[3:0];
  endtask

  // Driver: a word is taken when start is high and busy is low.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        if (select_route(live_word, want_route)) begin
          expected_routes.insert(expected_routes.size(), want_route);
        end
        words_taken++;
      end
      if (!start || !busy) begin
        if (pending_words.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          live_word = pending_words.pop_front();
          mode      <= live_word.mode;
          vnet      <= live_word.vnet;
          link      <= live_word.link;
          dest_mask <= live_word.dest;
          weight    <= live_word.weight;
          free_vcs  <= live_word.free_vcs;
          start     <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: each done strobe is matched against the oldest expected route.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_routes.size() == 0) begin
        $display("%0t: unexpected result word out_link=%0d no_route=%0b",
                 $time, out_link, no_route);
        errors++;
      end else begin
        got_route = expected_routes.pop_front();
        if (out_link !== got_route.out_link) begin
          $display("%0t: out_link mismatch expected %0d actual %0d",
                   $time, got_route.out_link, out_link);
          errors++;
        end
        if (no_route !== got_route.no_route) begin
          $display("%0t: no_route mismatch expected %0b actual %0b",
                   $time, got_route.no_route, no_route);
          errors++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int         left;
    int         batch;
    logic [31:0] setting;
    for (int v = 0; v < 4; v++)
      for (int l = 0; l < 8; l++) mask_table[v][l] = '0;
    for (int l = 0; l < 8; l++) weight_table[l] = '0;
    pick_state   = LFSR_SEED;
    ordered_bits = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    cfg_write(ORDERED_ADDR, 32'h0);

    // Directed words: empty tables, weight extremes, ties, no route and full free counts.
    queue_word(make_word(MODE_TABLE, 2'd0, 3'd0, '1, 16'h0, 32'h0));
    queue_word(make_word(MODE_ADAPT, 2'd3, 3'd7, '0, 16'hFFFF, '1));
    queue_word(make_word(MODE_MASK_WR, 2'd0, 3'd0, 64'h1, 16'h0, 32'h0));
    queue_word(make_word(MODE_MASK_WR, 2'd0, 3'd3, 64'h8000_0000_0000_0001, 16'h0, 32'h0));
    queue_word(make_word(MODE_MASK_WR, 2'd0, 3'd5, '1, 16'h0, 32'h0));
    queue_word(make_word(MODE_MASK_WR, 2'd0, 3'd7, 64'h8000_0000_0000_0000, 16'h0, 32'h0));
    queue_word(make_word(MODE_WEIGHT_WR, 2'd0, 3'd0, '0, 16'd5, 32'h0));
    queue_word(make_word(MODE_WEIGHT_WR, 2'd0, 3'd3, '0, 16'd5, 32'h0));
    queue_word(make_word(MODE_WEIGHT_WR, 2'd0, 3'd5, '0, 16'hFFFF, 32'h0));
    queue_word(make_word(MODE_WEIGHT_WR, 2'd0, 3'd7, '0, 16'd5, 32'h0));
    queue_word(make_word(MODE_TABLE, 2'd0, 3'd0, 64'h1, 16'h0, 32'h0));
    queue_word(make_word(MODE_ADAPT, 2'd0, 3'd0, 64'h1, 16'h0, 32'h3333_3333));
    queue_word(make_word(MODE_ADAPT, 2'd0, 3'd0, 64'h1, 16'h0, 32'h0000_F001));
    queue_word(make_word(MODE_TABLE, 2'd0, 3'd0, 64'h8000_0000_0000_0000, 16'h0, 32'h0));
    queue_word(make_word(MODE_TABLE, 2'd0, 3'd0, 64'h8000_0000_0000_0000, 16'h0, 32'h0));
    queue_word(make_word(MODE_WEIGHT_WR, 2'd0, 3'd5, '0, 16'h0, 32'h0));
    queue_word(make_word(MODE_TABLE, 2'd0, 3'd0, '1, 16'h0, 32'h0));
    queue_word(make_word(MODE_ADAPT, 2'd0, 3'd0, '0, 16'h0, '1));
    queue_word(make_word(MODE_MASK_WR, 2'd3, 3'd7, '1, 16'h0, 32'h0));
    queue_word(make_word(MODE_TABLE, 2'd3, 3'd0, 64'h0010_0000_0000_0000, 16'h0, 32'h0));
    queue_word(make_word(MODE_ADAPT, 2'd3, 3'd0, '1, 16'h0, '1));
    queue_word(make_word(MODE_ADAPT, 2'd3, 3'd0, 64'h2, 16'h0, 32'h0));

    // Random phases, each under its own ordered-vnet setting.
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clk);
      case (p)
        0:       setting = 32'hF;
        2:       setting = 32'h0;
        3:       setting = 32'h5;
        4:       setting = 32'hFFFF_FFFA;
        default: setting = $urandom;
      endcase
      cfg_write(ORDERED_ADDR, setting);
      if (p == 2) cfg_write(UNUSED_ADDR, $urandom);
      idle_pct = (p == 3) ? 0 : 25;
      left = PHASE_WORDS;
      while (left > 0) begin
        batch = $urandom_range(10, 60);
        if (batch > left) batch = left;
        repeat (batch) queue_word(random_word());
        left -= batch;
        // Now and then the sender holds off until every result is back.
        if ($urandom_range(0, 3) == 0) begin
          wait_drained();
        end else begin
          while (pending_words.size() > 8) @(posedge clk);
        end
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
